>>> sv/rtsp_pkg.sv
// Shared constants and widths for the round-trip shortest-path block.
package rtsp_pkg;

  // Default sizes of the node and edge stores.
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 16384;

  // Fixed field widths of the channels.
  localparam int NODE_W = 11;
  localparam int WT_W   = 10;
  localparam int DIST_W = 24;
  localparam int SUM_W  = 25;

  // Distance of a node not yet reached.
  localparam logic [DIST_W-1:0] FAR_DIST = 24'd10000001;

  // Configuration register indexes.
  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_TARGET_NODE = 1'b1;

endpackage

>>> sv/round_trip_shortest_path.sv
// Top level: edge loader, two Dijkstra searches and round-trip maximum.
//
// Usage: directed edges arrive on the in_ stream, one transfer each, with
// from_node, to_node and edge_weight in in_tdata and in_tlast marking the
// final edge of a run. Edges load at one per cycle into the edge memory;
// edges past MAX_EDGES are dropped and reported in out_tuser.
// After the last edge the block clears a distance memory before each
// search and runs Dijkstra from target_node forward and then over the
// reversed edges. Each settling step scans all nodes and then walks every
// stored edge, relaxing those that leave the settled node. A final pass
// over the nodes forms the largest forward-plus-reverse sum.
// The result leaves on out_ as one transfer from an output register.
// in_tready stays low from the last edge until the output register takes
// the result; the next run may then load while a stalled receiver holds it,
// and a later result waits in the sequencer until that register is free.
// Reset (rst_n low, synchronous) empties the edge count, drops any
// pending result and sets node_count and target_node to 1.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
module round_trip_shortest_path #(
  parameter int MAX_NODES = rtsp_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = rtsp_pkg::DEF_MAX_EDGES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // Fields from the lowest bit: from_node, to_node, edge_weight.
  input  logic [31:0]               in_tdata,
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // Fields from the lowest bit: longest_round_trip, zero fill.
  output logic [31:0]               out_tdata,
  // Fields from the lowest bit: edges_dropped.
  output logic                      out_tuser,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [rtsp_pkg::NODE_W-1:0] cfg_wdata
);
  import rtsp_pkg::*;

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam logic [NODE_W-1:0] MAXN = NODE_W'(MAX_NODES);
  localparam logic [CW-1:0]     MAXE = CW'(MAX_EDGES);
  localparam int EDGE_W = 2 * NODE_W + WT_W;
  localparam int ENT_W  = DIST_W + 1;

  // Sequencer states.
  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_TGT  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_PICK = 4'd4;
  localparam logic [3:0] S_ERD  = 4'd5;
  localparam logic [3:0] S_EDEC = 4'd6;
  localparam logic [3:0] S_ERLX = 4'd7;
  localparam logic [3:0] S_NDIR = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // Memories: edges, and per direction {settled, distance} by node - 1.
  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [ENT_W-1:0]  fwd_mem  [MAX_NODES];
  logic [ENT_W-1:0]  rev_mem  [MAX_NODES];

  logic [3:0]        state_r, state_nxt;
  logic [NODE_W-1:0] ncount_r, target_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              dir_r, dir_nxt;
  logic [NW-1:0]     idx_r, idx_nxt;
  logic [NW-1:0]     pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic              issued_r, issued_nxt;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic [SUM_W-1:0]  max_r, max_nxt;
  logic              found_r, found_nxt;
  logic [NW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     eidx_r, eidx_nxt;
  logic [DIST_W-1:0] cand_r, cand_nxt;
  logic [NW-1:0]     vidx_r, vidx_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [SUM_W-1:0]  odata_r, odata_nxt;
  logic              odrop_r, odrop_nxt;

  logic [EDGE_W-1:0] edge_q;
  logic [ENT_W-1:0]  fq, rq, dq;
  logic [NW-1:0]     rd_addr, wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic              wr_en;
  logic [EW-1:0]     erd_addr;

  logic [NODE_W-1:0] n_eff;
  logic [NW-1:0]     last_idx;
  logic              tgt_ok;
  logic              in_xfer;
  logic [NODE_W-1:0] e_u, e_v;
  logic [SUM_W-1:0]  sum;

  // Effective node count and target check.
  always_comb begin
    if (ncount_r == '0) begin
      n_eff = NODE_W'(1);
    end else if (ncount_r > MAXN) begin
      n_eff = MAXN;
    end else begin
      n_eff = ncount_r;
    end
  end
  assign last_idx = NW'(n_eff - NODE_W'(1));
  assign tgt_ok   = (target_r != '0) && (target_r <= n_eff);
  assign in_tready = (state_r == S_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign dq        = dir_r ? rq : fq;
  assign e_u       = dir_r ? edge_q[2*NODE_W-1:NODE_W] : edge_q[NODE_W-1:0];
  assign e_v       = dir_r ? edge_q[NODE_W-1:0] : edge_q[2*NODE_W-1:NODE_W];
  assign sum       = SUM_W'(fq[DIST_W-1:0]) + SUM_W'(rq[DIST_W-1:0]);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncount_r <= NODE_W'(1);
      target_r <= NODE_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NODE_COUNT:  ncount_r <= cfg_wdata;
        CFG_TARGET_NODE: target_r <= cfg_wdata;
        default:         ncount_r <= ncount_r;
      endcase
    end
  end

  // Edge memory: write on load, registered read for the walk.
  always_ff @(posedge clk) begin
    if (in_xfer && (cnt_r < MAXE)) begin
      edge_mem[cnt_r[EW-1:0]] <= in_tdata[EDGE_W-1:0];
    end
    edge_q <= edge_mem[erd_addr];
  end

  // Distance memories: one write port, registered read.
  always_ff @(posedge clk) begin
    if (wr_en && !dir_r) begin
      fwd_mem[wr_addr] <= wr_data;
    end
    if (wr_en && dir_r) begin
      rev_mem[wr_addr] <= wr_data;
    end
    fq <= fwd_mem[rd_addr];
    rq <= rev_mem[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    dir_nxt    = dir_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    pend_nxt   = 1'b0;
    issued_nxt = issued_r;
    best_nxt   = best_r;
    max_nxt    = max_r;
    found_nxt  = found_r;
    cur_nxt    = cur_r;
    eidx_nxt   = eidx_r;
    cand_nxt   = cand_r;
    vidx_nxt   = vidx_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    odrop_nxt  = odrop_r;
    rd_addr    = idx_r;
    wr_addr    = idx_r;
    wr_data    = {1'b0, FAR_DIST};
    wr_en      = 1'b0;
    erd_addr   = eidx_r[EW-1:0];

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (cnt_r < MAXE) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            dir_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = S_CLR;
          end
        end
      end
      // Clearing pass over nodes of the current direction.
      S_CLR: begin
        wr_en = 1'b1;
        idx_nxt = idx_r + NW'(1);
        if (idx_r == last_idx) begin
          state_nxt = tgt_ok ? S_TGT : S_NDIR;
        end
      end
      S_TGT: begin
        wr_addr = NW'(target_r - NODE_W'(1));
        wr_data = '0;
        wr_en   = 1'b1;
        idx_nxt = '0;
        issued_nxt = 1'b0;
        best_nxt   = FAR_DIST;
        found_nxt  = 1'b0;
        state_nxt  = S_SCAN;
      end
      // Minimum search over unsettled nodes, one read per cycle.
      S_SCAN: begin
        if (!issued_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + NW'(1);
          if (idx_r == last_idx) begin
            issued_nxt = 1'b1;
          end
        end
        if (pend_r && !dq[DIST_W] && (dq[DIST_W-1:0] < best_nxt)) begin
          best_nxt  = dq[DIST_W-1:0];
          cur_nxt   = pidx_r;
          found_nxt = 1'b1;
        end
        if (issued_r && !pend_r) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (!found_r) begin
          state_nxt = S_NDIR;
        end else begin
          wr_addr   = cur_r;
          wr_data   = {1'b1, best_r};
          wr_en     = 1'b1;
          eidx_nxt  = '0;
          state_nxt = S_ERD;
        end
      end
      // Edge walk: relax every edge that leaves the settled node.
      S_ERD: begin
        if (eidx_r == cnt_r) begin
          idx_nxt    = '0;
          issued_nxt = 1'b0;
          best_nxt   = FAR_DIST;
          found_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_EDEC;
        end
      end
      S_EDEC: begin
        if ((e_u == NODE_W'(cur_r) + NODE_W'(1)) && (e_v != '0) && (e_v <= n_eff)) begin
          vidx_nxt  = NW'(e_v - NODE_W'(1));
          rd_addr   = vidx_nxt;
          cand_nxt  = best_r + DIST_W'(edge_q[EDGE_W-1:2*NODE_W]);
          state_nxt = S_ERLX;
        end else begin
          eidx_nxt  = eidx_r + CW'(1);
          state_nxt = S_ERD;
        end
      end
      S_ERLX: begin
        if (cand_r < dq[DIST_W-1:0]) begin
          wr_addr = vidx_r;
          wr_data = {dq[DIST_W], cand_r};
          wr_en   = 1'b1;
        end
        eidx_nxt  = eidx_r + CW'(1);
        state_nxt = S_ERD;
      end
      S_NDIR: begin
        idx_nxt    = '0;
        issued_nxt = 1'b0;
        max_nxt    = '0;
        if (!dir_r) begin
          dir_nxt   = 1'b1;
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_SUM;
        end
      end
      // Largest forward-plus-reverse sum.
      S_SUM: begin
        if (!issued_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + NW'(1);
          if (idx_r == last_idx) begin
            issued_nxt = 1'b1;
          end
        end
        if (pend_r && (sum > max_nxt)) begin
          max_nxt = sum;
        end
        if (issued_r && !pend_r) begin
          state_nxt = S_OUT;
        end
      end
      // Hand the result over once the output register is free.
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = max_r;
          odrop_nxt  = ovf_r;
          cnt_nxt    = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      dir_r    <= 1'b0;
      pend_r   <= 1'b0;
      issued_r <= 1'b0;
      found_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      dir_r    <= dir_nxt;
      pend_r   <= pend_nxt;
      issued_r <= issued_nxt;
      found_r  <= found_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    best_r  <= best_nxt;
    max_r   <= max_nxt;
    cur_r   <= cur_nxt;
    eidx_r  <= eidx_nxt;
    cand_r  <= cand_nxt;
    vidx_r  <= vidx_nxt;
    odata_r <= odata_nxt;
    odrop_r <= odrop_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(32-SUM_W){1'b0}}, odata_r};
  assign out_tuser  = odrop_r;

  // The edge count never passes the store size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXE) else $error("edge count beyond store");

  // A settled node always carries a reached distance.
  a_pick_far: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) && found_r |-> best_r < FAR_DIST)
    else $error("settled node not reached");

  // A run's last edge starts the search and closes the input.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> !in_tready) else $error("input open after last edge");

endmodule
